// ===== sv/srclex_pkg.sv =====
package srclex_pkg;

  localparam logic [3:0] KIND_INVALID = 4'd0;
  localparam logic [3:0] KIND_IDENT   = 4'd1;
  localparam logic [3:0] KIND_ENDSTMT = 4'd2;
  localparam logic [3:0] KIND_ENDFILE = 4'd3;
  localparam logic [3:0] KIND_RETURN  = 4'd4;
  localparam logic [3:0] KIND_INT     = 4'd5;
  localparam logic [3:0] KIND_FLOAT   = 4'd6;
  localparam logic [3:0] KIND_LBRACE  = 4'd7;
  localparam logic [3:0] KIND_RBRACE  = 4'd8;
  localparam logic [3:0] KIND_ASSIGN  = 4'd9;
  localparam logic [3:0] KIND_COMMA   = 4'd10;
  localparam logic [3:0] KIND_LPAREN  = 4'd11;
  localparam logic [3:0] KIND_RPAREN  = 4'd12;
  localparam logic [3:0] KIND_BUILD   = 4'd13;

  localparam logic [1:0] ERR_NONE       = 2'd0;
  localparam logic [1:0] ERR_INVALID    = 2'd1;
  localparam logic [1:0] ERR_BAD_JOIN   = 2'd2;
  localparam logic [1:0] ERR_OPEN_BLOCK = 2'd3;

  localparam int TDATA_OUT_W = 72;

  typedef struct packed {
    logic [1:0]  error_code;
    logic [31:0] tok_len;
    logic [31:0] start_offset;
    logic [3:0]  tok_kind;
  } token_t;

endpackage

// ===== sv/srclex_scanner.sv =====
module srclex_scanner #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                advance,
  input  logic                action,
  input  logic [7:0]          byte_value,
  output logic                tok_a_valid,
  output srclex_pkg::token_t  tok_a,
  output logic                tok_b_valid,
  output srclex_pkg::token_t  tok_b
);

  typedef enum logic [3:0] {
    M_IDLE       = 4'd0,
    M_IDENT      = 4'd1,
    M_INT        = 4'd2,
    M_FLOAT      = 4'd3,
    M_SLASH      = 4'd4,
    M_LINE       = 4'd5,
    M_BLOCK      = 4'd6,
    M_BLOCK_STAR = 4'd7,
    M_JOIN       = 4'd8
  } mode_t;

  localparam logic [3:0] KP_NONE   = 4'd0;
  localparam logic [3:0] KP_R      = 4'd1;
  localparam logic [3:0] KP_RETURN = 4'd6;
  localparam logic [3:0] KP_B      = 4'd7;
  localparam logic [3:0] KP_BUILD  = 4'd11;

  mode_t                   mode, mode_next;
  logic [OFFSET_WIDTH-1:0] pending_start, pending_start_next;
  logic [OFFSET_WIDTH-1:0] byte_position, byte_position_next;
  logic [3:0]              last_kept_kind, last_kept_kind_next;
  logic                    any_token_kept, any_token_kept_next;
  logic [3:0]              keyword_progress, keyword_progress_next;

  logic [OFFSET_WIDTH-1:0] span;
  logic [31:0]             span_len;
  logic                    consumed;
  logic [3:0]              mid_kind;
  logic                    mid_any;
  logic [3:0]              sym;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09) || (c == 8'h0d);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_letter(input logic [7:0] c);
    return c[7] || ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || (c == "_");
  endfunction

  function automatic logic [3:0] kw_next(input logic [3:0] p, input logic [7:0] c);
    logic hit;
    unique case (p)
      4'd1:    hit = (c == "e");
      4'd2:    hit = (c == "t");
      4'd3:    hit = (c == "u");
      4'd4:    hit = (c == "r");
      4'd5:    hit = (c == "n");
      4'd7:    hit = (c == "u");
      4'd8:    hit = (c == "i");
      4'd9:    hit = (c == "l");
      4'd10:   hit = (c == "d");
      default: hit = 1'b0;
    endcase
    return hit ? p + 4'd1 : KP_NONE;
  endfunction

  function automatic logic [3:0] ident_kind(input logic [3:0] p);
    if (p == KP_RETURN) return srclex_pkg::KIND_RETURN;
    if (p == KP_BUILD) return srclex_pkg::KIND_BUILD;
    return srclex_pkg::KIND_IDENT;
  endfunction

  function automatic logic ends_statement(input logic [3:0] k);
    return !((k == srclex_pkg::KIND_LBRACE) || (k == srclex_pkg::KIND_ASSIGN) ||
             (k == srclex_pkg::KIND_ENDSTMT) || (k == srclex_pkg::KIND_COMMA) ||
             (k == srclex_pkg::KIND_LPAREN));
  endfunction

  function automatic srclex_pkg::token_t make_tok(input logic [3:0] kind,
      input logic [31:0] start, input logic [31:0] len, input logic [1:0] err);
    srclex_pkg::token_t t;
    t.tok_kind     = kind;
    t.start_offset = start;
    t.tok_len      = len;
    t.error_code   = err;
    return t;
  endfunction

  always_comb begin
    span     = byte_position - pending_start;
    span_len = 32'(span);
    if ((span >> 32) != '0) begin
      span_len = '1;
    end
  end

  always_comb begin
    unique case (byte_value)
      "{":     sym = srclex_pkg::KIND_LBRACE;
      "}":     sym = srclex_pkg::KIND_RBRACE;
      "=":     sym = srclex_pkg::KIND_ASSIGN;
      ";":     sym = srclex_pkg::KIND_ENDSTMT;
      ",":     sym = srclex_pkg::KIND_COMMA;
      "(":     sym = srclex_pkg::KIND_LPAREN;
      ")":     sym = srclex_pkg::KIND_RPAREN;
      default: sym = srclex_pkg::KIND_INVALID;
    endcase
  end

  always_comb begin
    mode_next             = mode;
    pending_start_next    = pending_start;
    byte_position_next    = byte_position + OFFSET_WIDTH'(1);
    last_kept_kind_next   = last_kept_kind;
    any_token_kept_next   = any_token_kept;
    keyword_progress_next = keyword_progress;
    tok_a_valid           = 1'b0;
    tok_b_valid           = 1'b0;
    tok_a                 = '0;
    tok_b                 = '0;
    consumed              = 1'b0;
    mid_kind              = last_kept_kind;
    mid_any               = any_token_kept;

    if (action) begin
      unique case (mode)
        M_IDENT: begin
          tok_a_valid = 1'b1;
          tok_a = make_tok(ident_kind(keyword_progress), 32'(pending_start), span_len,
                           srclex_pkg::ERR_NONE);
        end
        M_INT: begin
          tok_a_valid = 1'b1;
          tok_a = make_tok(srclex_pkg::KIND_INT, 32'(pending_start), span_len,
                           srclex_pkg::ERR_NONE);
        end
        M_FLOAT: begin
          tok_a_valid = 1'b1;
          tok_a = make_tok(srclex_pkg::KIND_FLOAT, 32'(pending_start), span_len,
                           srclex_pkg::ERR_NONE);
        end
        M_SLASH: begin
          tok_a_valid = 1'b1;
          tok_a = make_tok(srclex_pkg::KIND_INVALID, 32'(pending_start), 32'd1,
                           srclex_pkg::ERR_INVALID);
        end
        M_JOIN: begin
          tok_a_valid = 1'b1;
          tok_a = make_tok(srclex_pkg::KIND_INVALID, 32'(pending_start), span_len,
                           srclex_pkg::ERR_BAD_JOIN);
        end
        M_BLOCK, M_BLOCK_STAR: begin
          tok_a_valid = 1'b1;
          tok_a = make_tok(srclex_pkg::KIND_INVALID, 32'(pending_start), span_len,
                           srclex_pkg::ERR_OPEN_BLOCK);
        end
        default: ;
      endcase
      tok_b_valid = 1'b1;
      if (byte_position == '0) begin
        tok_b = make_tok(srclex_pkg::KIND_ENDFILE, 32'd0, 32'd0, srclex_pkg::ERR_NONE);
      end else begin
        tok_b = make_tok(srclex_pkg::KIND_ENDFILE, 32'(byte_position - OFFSET_WIDTH'(1)),
                         32'd1, srclex_pkg::ERR_NONE);
      end
      mode_next             = M_IDLE;
      pending_start_next    = '0;
      byte_position_next    = '0;
      last_kept_kind_next   = srclex_pkg::KIND_INVALID;
      any_token_kept_next   = 1'b0;
      keyword_progress_next = KP_NONE;
    end else begin
      unique case (mode)
        M_IDENT: begin
          if (is_letter(byte_value) || is_digit(byte_value)) begin
            keyword_progress_next = kw_next(keyword_progress, byte_value);
            consumed = 1'b1;
          end else begin
            tok_a_valid = 1'b1;
            tok_a = make_tok(ident_kind(keyword_progress), 32'(pending_start), span_len,
                             srclex_pkg::ERR_NONE);
            mode_next = M_IDLE;
          end
        end
        M_INT: begin
          if (is_digit(byte_value)) begin
            consumed = 1'b1;
          end else if (byte_value == ".") begin
            mode_next = M_FLOAT;
            consumed = 1'b1;
          end else begin
            tok_a_valid = 1'b1;
            tok_a = make_tok(srclex_pkg::KIND_INT, 32'(pending_start), span_len,
                             srclex_pkg::ERR_NONE);
            mode_next = M_IDLE;
          end
        end
        M_FLOAT: begin
          if (is_digit(byte_value)) begin
            consumed = 1'b1;
          end else begin
            tok_a_valid = 1'b1;
            tok_a = make_tok(srclex_pkg::KIND_FLOAT, 32'(pending_start), span_len,
                             srclex_pkg::ERR_NONE);
            mode_next = M_IDLE;
          end
        end
        M_SLASH: begin
          if (byte_value == "/") begin
            mode_next = M_LINE;
            consumed = 1'b1;
          end else if (byte_value == "*") begin
            mode_next = M_BLOCK;
            consumed = 1'b1;
          end else begin
            tok_a_valid = 1'b1;
            tok_a = make_tok(srclex_pkg::KIND_INVALID, 32'(pending_start), 32'd1,
                             srclex_pkg::ERR_INVALID);
            mode_next = M_IDLE;
          end
        end
        M_LINE: begin
          if (byte_value == 8'h0a) begin
            mode_next = M_IDLE;
          end else begin
            consumed = 1'b1;
          end
        end
        M_BLOCK: begin
          if (byte_value == "*") begin
            mode_next = M_BLOCK_STAR;
          end
          consumed = 1'b1;
        end
        M_BLOCK_STAR: begin
          if (byte_value == "/") begin
            mode_next = M_IDLE;
          end else if (byte_value != "*") begin
            mode_next = M_BLOCK;
          end
          consumed = 1'b1;
        end
        M_JOIN: begin
          if (is_blank(byte_value)) begin
            consumed = 1'b1;
          end else if (byte_value == 8'h0a) begin
            mode_next = M_IDLE;
            consumed = 1'b1;
          end else begin
            tok_a_valid = 1'b1;
            tok_a = make_tok(srclex_pkg::KIND_INVALID, 32'(pending_start), span_len,
                             srclex_pkg::ERR_BAD_JOIN);
            mode_next = M_IDLE;
          end
        end
        default: begin
          mode_next = M_IDLE;
        end
      endcase

      if (tok_a_valid && (tok_a.error_code == srclex_pkg::ERR_NONE) &&
          (tok_a.tok_kind != srclex_pkg::KIND_INVALID)) begin
        mid_kind = tok_a.tok_kind;
        mid_any  = 1'b1;
      end

      if (!consumed && !is_blank(byte_value)) begin
        if (byte_value == 8'h0a) begin
          if (mid_any && ends_statement(mid_kind)) begin
            tok_b_valid = 1'b1;
            tok_b = make_tok(srclex_pkg::KIND_ENDSTMT, 32'(byte_position), 32'd1,
                             srclex_pkg::ERR_NONE);
          end
        end else begin
          pending_start_next = byte_position;
          if (byte_value == "\\") begin
            mode_next = M_JOIN;
          end else if (byte_value == "/") begin
            mode_next = M_SLASH;
          end else if (is_letter(byte_value)) begin
            mode_next = M_IDENT;
            keyword_progress_next = (byte_value == "r") ? KP_R :
                                    (byte_value == "b") ? KP_B : KP_NONE;
          end else if (is_digit(byte_value)) begin
            mode_next = M_INT;
          end else if (byte_value == ".") begin
            mode_next = M_FLOAT;
          end else begin
            tok_b_valid = 1'b1;
            tok_b = make_tok(sym, 32'(byte_position), 32'd1,
                             (sym == srclex_pkg::KIND_INVALID) ? srclex_pkg::ERR_INVALID
                                                               : srclex_pkg::ERR_NONE);
          end
        end
      end

      last_kept_kind_next = mid_kind;
      any_token_kept_next = mid_any;
      if (tok_b_valid && (tok_b.error_code == srclex_pkg::ERR_NONE) &&
          (tok_b.tok_kind != srclex_pkg::KIND_INVALID)) begin
        last_kept_kind_next = tok_b.tok_kind;
        any_token_kept_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= M_IDLE;
      pending_start    <= '0;
      byte_position    <= '0;
      last_kept_kind   <= srclex_pkg::KIND_INVALID;
      any_token_kept   <= 1'b0;
      keyword_progress <= KP_NONE;
    end else if (advance) begin
      mode             <= mode_next;
      pending_start    <= pending_start_next;
      byte_position    <= byte_position_next;
      last_kept_kind   <= last_kept_kind_next;
      any_token_kept   <= any_token_kept_next;
      keyword_progress <= keyword_progress_next;
    end
  end

endmodule

// ===== sv/srclex_out_buf.sv =====
module srclex_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                tok_a_valid,
  input  srclex_pkg::token_t  tok_a,
  input  logic                tok_b_valid,
  input  srclex_pkg::token_t  tok_b,
  output logic                room,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output srclex_pkg::token_t  head,
  output logic                head_last
);

  logic [1:0]         count, count_next;
  srclex_pkg::token_t slot0, slot1;
  logic               last0, last1;
  logic               pop;

  assign pop           = (count != 2'd0) && m_axis_tready;
  assign room          = (count == 2'd0) || ((count == 2'd1) && m_axis_tready);
  assign m_axis_tvalid = (count != 2'd0);
  assign head          = slot0;
  assign head_last     = last0;
  assign count_next    = 2'(tok_a_valid) + 2'(tok_b_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else if (push) begin
      count <= count_next;
    end else if (pop) begin
      count <= count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (tok_a_valid) begin
        slot0 <= tok_a;
        last0 <= !tok_b_valid;
        slot1 <= tok_b;
        last1 <= 1'b1;
      end else begin
        slot0 <= tok_b;
        last0 <= 1'b1;
      end
    end else if (pop) begin
      slot0 <= slot1;
      last0 <= last1;
    end
  end

endmodule

// ===== sv/source_lexer_newline_statements_unit.sv =====
// Byte-stream lexer. Each accepted word is one source byte (tuser low) or an end-of-input
// marker (tuser high); tokens leave one per word with kind, start offset, length and error
// code, tlast marking the final token caused by that input word. A byte lands in an input
// register, is scanned against the registered scanner state and its tokens are written to a
// two-entry result buffer, which presents them; while the buffer has no room the byte waits in
// the input register. One byte is taken per cycle while each byte yields at most one token and
// the result port is ready; a byte that closes one token and emits another, or an end-of-input
// marker with a pending token, yields two and holds the input until the first has left, since
// the result port delivers one word per cycle. After end of input the offset restarts at zero.
// Offsets are OFFSET_WIDTH bits wide, wrap, and are reported in their low 32 bits; lengths
// saturate at all ones.
module source_lexer_newline_statements_unit #(
  parameter int OFFSET_WIDTH = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [7:0]                         s_axis_tdata,  // byte_value
  input  logic                               s_axis_tuser,  // action
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tok_kind[3:0], start_offset[35:4], tok_len[67:36], error_code[69:68], zero[71:70]
  output logic [srclex_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  output logic                               m_axis_tlast   // last_of_run
);

  logic               in_valid;
  logic               in_action;
  logic [7:0]         in_byte;
  logic               room;
  logic               advance;
  logic               tok_a_valid, tok_b_valid;
  srclex_pkg::token_t tok_a, tok_b;
  srclex_pkg::token_t head;

  assign advance       = in_valid && room;
  assign s_axis_tready = !in_valid || room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_action <= s_axis_tuser;
      in_byte   <= s_axis_tdata;
    end
  end

  srclex_scanner #(
    .OFFSET_WIDTH(OFFSET_WIDTH)
  ) u_scanner (
    .clk         (clk),
    .rst         (rst),
    .advance     (advance),
    .action      (in_action),
    .byte_value  (in_byte),
    .tok_a_valid (tok_a_valid),
    .tok_a       (tok_a),
    .tok_b_valid (tok_b_valid),
    .tok_b       (tok_b)
  );

  srclex_out_buf u_out_buf (
    .clk           (clk),
    .rst           (rst),
    .push          (advance),
    .tok_a_valid   (tok_a_valid),
    .tok_a         (tok_a),
    .tok_b_valid   (tok_b_valid),
    .tok_b         (tok_b),
    .room          (room),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .head          (head),
    .head_last     (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, head};

endmodule
